[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define WPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("Assertion failed.");

// Checked on every rising clock edge, reset included.
`define WPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("Assertion failed.");

`endif

[hdl/wpc_pkg.sv]
// ----------------------------------------------------------------------------
// wpc_pkg
// Types, constants and saturation helpers of the 2D weighted point combiner.
// ----------------------------------------------------------------------------
package wpc_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int WEIGHT_FRAC  = FRAC_BITS + FRAC_BITS / 2;
    localparam int WEIGHT_WIDTH = 48;
    localparam int WPOS_WIDTH   = 64;
    localparam int COV_WIDTH    = VALUE_WIDTH + 2;
    localparam int SHIFT_K      = WEIGHT_FRAC + FRAC_BITS;
    localparam int XW           = 128;
    localparam int CNT_W        = $clog2(XW);

    localparam logic [CNT_W-1:0] CNT_MUL_V   = CNT_W'(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_MUL_W   = CNT_W'(WEIGHT_WIDTH);
    localparam logic [CNT_W-1:0] CNT_MUL_C   = CNT_W'(COV_WIDTH);
    localparam logic [CNT_W-1:0] CNT_DIV_IN  = CNT_W'(SHIFT_K + VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_DIV_CMB = CNT_W'(SHIFT_K + WEIGHT_WIDTH);

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IN_SING   = 2'd1;
    localparam logic [1:0] ST_COMB_SING = 2'd2;

    typedef logic signed [XW-1:0] t_wide;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M1, S_M2,
        S_D1, S_D2, S_D3,
        S_Q1, S_Q2, S_Q3, S_Q4,
        S_UPD,
        S_C1, S_C2,
        S_E1, S_E2, S_E3,
        S_R1, S_R2, S_R3, S_R4,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [VALUE_WIDTH-1:0] pos_x;
        logic signed [VALUE_WIDTH-1:0] pos_y;
        logic [VALUE_WIDTH-1:0]        var_xx;
        logic signed [VALUE_WIDTH-1:0] var_xy;
        logic [VALUE_WIDTH-1:0]        var_yy;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] comb_x;
        logic signed [VALUE_WIDTH-1:0] comb_y;
        logic signed [VALUE_WIDTH-1:0] comb_xx;
        logic signed [VALUE_WIDTH-1:0] comb_xy;
        logic signed [VALUE_WIDTH-1:0] comb_yy;
        logic [1:0]                    status;
    } t_out_item;

    function automatic t_wide sat_w(input t_wide x, input int unsigned bits);
        t_wide mx;
        mx = (t_wide'(1) <<< (bits - 1)) - t_wide'(1);
        if (x > mx) begin
            return mx;
        end else if (x < -mx - t_wide'(1)) begin
            return -mx - t_wide'(1);
        end
        return x;
    endfunction

endpackage

[hdl/weighted_point_combiner_2d_top.sv]
// ----------------------------------------------------------------------------
// weighted_point_combiner_2d_top
// Running information-form combination of 2D points in signed Q16.16.
// ----------------------------------------------------------------------------
// A singular combination skips its inversion and position products. The block
// takes one item at a time. Its pace is set by the single bit-serial
// multiply/divide unit: every product takes one multiplier bit per cycle (32,
// 34 or 48 bits), every quotient one dividend bit per cycle (72 or 88 bits).
// A finished result waits in an output register, so the next item is taken
// while the previous result is still pending.
module weighted_point_combiner_2d_top import wpc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_in_item               i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_out_item              o_data,
    input  logic                   i_cfg_we,
    input  logic [VALUE_WIDTH-1:0] i_cfg_wdata
);

    t_state                        r_state, n_state;
    logic                          r_wait, n_wait;
    logic                          r_ovalid, n_ovalid;
    logic [VALUE_WIDTH-1:0]        r_ev;
    logic [1:0]                    r_kind;
    logic [1:0]                    r_status, n_status;
    logic                          r_csing, n_csing;
    logic signed [VALUE_WIDTH-1:0] r_a, r_b, r_d, r_px, r_py;
    t_wide                         r_t0, n_t0, r_det, n_det;
    logic signed [WEIGHT_WIDTH-1:0] r_nxx, n_nxx, r_nxy, n_nxy, r_nyy, n_nyy;
    logic signed [WPOS_WIDTH-1:0]  r_qx, n_qx, r_qy, n_qy;
    logic signed [WEIGHT_WIDTH-1:0] r_wxx, n_wxx, r_wxy, n_wxy, r_wyy, n_wyy;
    logic signed [WPOS_WIDTH-1:0]  r_wx, n_wx, r_wy, n_wy;
    logic signed [COV_WIDTH-1:0]   r_cxx, n_cxx, r_cxy, n_cxy, r_cyy, n_cyy;
    logic signed [VALUE_WIDTH-1:0] r_ox, n_ox, r_oy, n_oy;
    t_out_item                     r_out, n_out;

    logic                          alu_start, alu_done;
    t_alu_op                       alu_op;
    t_wide                         alu_a, alu_b, alu_res, sum, dsub, ev_w;
    logic [CNT_W-1:0]              alu_cnt;
    logic                          in_acc;
    logic [VALUE_WIDTH:0]          sum_xx, sum_yy;
    logic signed [VALUE_WIDTH-1:0] sat_xx, sat_yy;
    localparam logic [VALUE_WIDTH:0] V_MAX = (VALUE_WIDTH+1)'({(VALUE_WIDTH-1){1'b1}});

    wpc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_cnt   (alu_cnt),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    assign in_acc = i_valid && o_ready;
    assign sum_xx = {1'b0, i_data.var_xx} + {1'b0, r_ev};
    assign sum_yy = {1'b0, i_data.var_yy} + {1'b0, r_ev};
    assign sat_xx = (sum_xx > V_MAX) ? VALUE_WIDTH'(V_MAX) : VALUE_WIDTH'(sum_xx);
    assign sat_yy = (sum_yy > V_MAX) ? VALUE_WIDTH'(V_MAX) : VALUE_WIDTH'(sum_yy);
    assign ev_w   = t_wide'(signed'({1'b0, r_ev}));
    assign sum    = r_t0 + alu_res;
    assign dsub   = r_t0 - alu_res;

    always_comb begin
        alu_op  = ALU_MUL;
        alu_a   = '0;
        alu_b   = '0;
        alu_cnt = CNT_MUL_V;
        unique case (r_state)
            S_M1: begin alu_a = t_wide'(r_a); alu_b = t_wide'(r_d); end
            S_M2: begin alu_a = t_wide'(r_b); alu_b = t_wide'(r_b); end
            S_D1, S_D2, S_D3: begin
                alu_op  = ALU_DIV;
                alu_b   = r_det;
                alu_cnt = CNT_DIV_IN;
                if (r_state == S_D1) begin
                    alu_a = t_wide'(r_d) <<< SHIFT_K;
                end else if (r_state == S_D2) begin
                    alu_a = (-t_wide'(r_b)) <<< SHIFT_K;
                end else begin
                    alu_a = t_wide'(r_a) <<< SHIFT_K;
                end
            end
            S_Q1: begin alu_a = t_wide'(r_nxx); alu_b = t_wide'(r_px); end
            S_Q2: begin alu_a = t_wide'(r_nxy); alu_b = t_wide'(r_py); end
            S_Q3: begin alu_a = t_wide'(r_nxy); alu_b = t_wide'(r_px); end
            S_Q4: begin alu_a = t_wide'(r_nyy); alu_b = t_wide'(r_py); end
            S_C1: begin
                alu_a = t_wide'(r_wxx); alu_b = t_wide'(r_wyy); alu_cnt = CNT_MUL_W;
            end
            S_C2: begin
                alu_a = t_wide'(r_wxy); alu_b = t_wide'(r_wxy); alu_cnt = CNT_MUL_W;
            end
            S_E1, S_E2, S_E3: begin
                alu_op  = ALU_DIV;
                alu_b   = r_det;
                alu_cnt = CNT_DIV_CMB;
                if (r_state == S_E1) begin
                    alu_a = t_wide'(r_wyy) <<< SHIFT_K;
                end else if (r_state == S_E2) begin
                    alu_a = (-t_wide'(r_wxy)) <<< SHIFT_K;
                end else begin
                    alu_a = t_wide'(r_wxx) <<< SHIFT_K;
                end
            end
            S_R1: begin alu_a = t_wide'(r_wx); alu_b = t_wide'(r_cxx); alu_cnt = CNT_MUL_C; end
            S_R2: begin alu_a = t_wide'(r_wy); alu_b = t_wide'(r_cxy); alu_cnt = CNT_MUL_C; end
            S_R3: begin alu_a = t_wide'(r_wx); alu_b = t_wide'(r_cxy); alu_cnt = CNT_MUL_C; end
            S_R4: begin alu_a = t_wide'(r_wy); alu_b = t_wide'(r_cyy); alu_cnt = CNT_MUL_C; end
            default: begin end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_csing  = r_csing;
        n_t0  = r_t0;  n_det = r_det;
        n_nxx = r_nxx; n_nxy = r_nxy; n_nyy = r_nyy;
        n_qx  = r_qx;  n_qy  = r_qy;
        n_wxx = r_wxx; n_wxy = r_wxy; n_wyy = r_wyy;
        n_wx  = r_wx;  n_wy  = r_wy;
        n_cxx = r_cxx; n_cxy = r_cxy; n_cyy = r_cyy;
        n_ox  = r_ox;  n_oy  = r_oy;
        n_out = r_out;
        alu_start = 1'b0;
        o_ready   = (r_state == S_IDLE);
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_csing  = 1'b0;
                    n_state  = (i_data.kind == KIND_LOAD || i_data.kind == KIND_ADD ||
                                i_data.kind == KIND_REMOVE) ? S_M1 : S_C1;
                end
            end
            S_UPD: begin
                if (r_kind == KIND_LOAD) begin
                    n_wxx = r_nxx; n_wxy = r_nxy; n_wyy = r_nyy;
                    n_wx  = r_qx;  n_wy  = r_qy;
                end else if (r_kind == KIND_ADD) begin
                    n_wxx = WEIGHT_WIDTH'(sat_w(t_wide'(r_wxx) + t_wide'(r_nxx), WEIGHT_WIDTH));
                    n_wxy = WEIGHT_WIDTH'(sat_w(t_wide'(r_wxy) + t_wide'(r_nxy), WEIGHT_WIDTH));
                    n_wyy = WEIGHT_WIDTH'(sat_w(t_wide'(r_wyy) + t_wide'(r_nyy), WEIGHT_WIDTH));
                    n_wx  = WPOS_WIDTH'(sat_w(t_wide'(r_wx) + t_wide'(r_qx), WPOS_WIDTH));
                    n_wy  = WPOS_WIDTH'(sat_w(t_wide'(r_wy) + t_wide'(r_qy), WPOS_WIDTH));
                end else begin
                    n_wxx = WEIGHT_WIDTH'(sat_w(t_wide'(r_wxx) - t_wide'(r_nxx), WEIGHT_WIDTH));
                    n_wxy = WEIGHT_WIDTH'(sat_w(t_wide'(r_wxy) - t_wide'(r_nxy), WEIGHT_WIDTH));
                    n_wyy = WEIGHT_WIDTH'(sat_w(t_wide'(r_wyy) - t_wide'(r_nyy), WEIGHT_WIDTH));
                    n_wx  = WPOS_WIDTH'(sat_w(t_wide'(r_wx) - t_wide'(r_qx), WPOS_WIDTH));
                    n_wy  = WPOS_WIDTH'(sat_w(t_wide'(r_wy) - t_wide'(r_qy), WPOS_WIDTH));
                end
                n_state = S_C1;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid       = 1'b1;
                    n_out.status   = r_status;
                    n_out.comb_x   = r_csing ? '0 : r_ox;
                    n_out.comb_y   = r_csing ? '0 : r_oy;
                    n_out.comb_xx  = r_csing ? '0 :
                        VALUE_WIDTH'(sat_w(t_wide'(r_cxx) - ev_w, VALUE_WIDTH));
                    n_out.comb_xy  = r_csing ? '0 :
                        VALUE_WIDTH'(sat_w(t_wide'(r_cxy), VALUE_WIDTH));
                    n_out.comb_yy  = r_csing ? '0 :
                        VALUE_WIDTH'(sat_w(t_wide'(r_cyy) - ev_w, VALUE_WIDTH));
                    n_state        = S_IDLE;
                end
            end
            default: begin
                if (!r_wait) begin
                    alu_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (alu_done) begin
                    n_wait = 1'b0;
                    case (r_state)
                        S_M1: begin n_t0 = alu_res; n_state = S_M2; end
                        S_M2: begin
                            n_det = dsub;
                            if (dsub == '0) begin
                                n_status = ST_IN_SING;
                                n_state  = S_C1;
                            end else begin
                                n_state = S_D1;
                            end
                        end
                        S_D1: begin
                            n_nxx = WEIGHT_WIDTH'(sat_w(alu_res, WEIGHT_WIDTH)); n_state = S_D2;
                        end
                        S_D2: begin
                            n_nxy = WEIGHT_WIDTH'(sat_w(alu_res, WEIGHT_WIDTH)); n_state = S_D3;
                        end
                        S_D3: begin
                            n_nyy = WEIGHT_WIDTH'(sat_w(alu_res, WEIGHT_WIDTH)); n_state = S_Q1;
                        end
                        S_Q1: begin n_t0 = alu_res; n_state = S_Q2; end
                        S_Q2: begin
                            n_qx = WPOS_WIDTH'(sat_w(sum >>> FRAC_BITS, WPOS_WIDTH));
                            n_state = S_Q3;
                        end
                        S_Q3: begin n_t0 = alu_res; n_state = S_Q4; end
                        S_Q4: begin
                            n_qy = WPOS_WIDTH'(sat_w(sum >>> FRAC_BITS, WPOS_WIDTH));
                            n_state = S_UPD;
                        end
                        S_C1: begin n_t0 = alu_res; n_state = S_C2; end
                        S_C2: begin
                            n_det = dsub;
                            if (dsub == '0) begin
                                n_csing = 1'b1;
                                if (r_status == ST_OK) begin
                                    n_status = ST_COMB_SING;
                                end
                                n_state = S_DONE;
                            end else begin
                                n_state = S_E1;
                            end
                        end
                        S_E1: begin
                            n_cxx = COV_WIDTH'(sat_w(alu_res, COV_WIDTH)); n_state = S_E2;
                        end
                        S_E2: begin
                            n_cxy = COV_WIDTH'(sat_w(alu_res, COV_WIDTH)); n_state = S_E3;
                        end
                        S_E3: begin
                            n_cyy = COV_WIDTH'(sat_w(alu_res, COV_WIDTH)); n_state = S_R1;
                        end
                        S_R1: begin n_t0 = alu_res; n_state = S_R2; end
                        S_R2: begin
                            n_ox = VALUE_WIDTH'(sat_w(sum >>> WEIGHT_FRAC, VALUE_WIDTH));
                            n_state = S_R3;
                        end
                        S_R3: begin n_t0 = alu_res; n_state = S_R4; end
                        S_R4: begin
                            n_oy = VALUE_WIDTH'(sat_w(sum >>> WEIGHT_FRAC, VALUE_WIDTH));
                            n_state = S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_ev     <= '0;
            r_wxx    <= '0;
            r_wxy    <= '0;
            r_wyy    <= '0;
            r_wx     <= '0;
            r_wy     <= '0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_ev <= i_cfg_wdata;
            end
            r_wxx <= n_wxx;
            r_wxy <= n_wxy;
            r_wyy <= n_wyy;
            r_wx  <= n_wx;
            r_wy  <= n_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_data.kind;
            r_a    <= sat_xx;
            r_b    <= i_data.var_xy;
            r_d    <= sat_yy;
            r_px   <= i_data.pos_x;
            r_py   <= i_data.pos_y;
        end
        r_status <= n_status;
        r_csing  <= n_csing;
        r_t0  <= n_t0;  r_det <= n_det;
        r_nxx <= n_nxx; r_nxy <= n_nxy; r_nyy <= n_nyy;
        r_qx  <= n_qx;  r_qy  <= n_qy;
        r_cxx <= n_cxx; r_cxy <= n_cxy; r_cyy <= n_cyy;
        r_ox  <= n_ox;  r_oy  <= n_oy;
        r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

[hdl/wpc_alu.sv]
// ----------------------------------------------------------------------------
// wpc_alu
// Shared bit-serial unit: signed shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module wpc_alu import wpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_alu_op          i_op,
    input  t_wide            i_a,
    input  t_wide            i_b,
    input  logic [CNT_W-1:0] i_cnt,
    output logic             o_done,
    output t_wide            o_res
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_alu_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [XW-1:0]    r_x, r_y, r_acc, r_q;
    logic             r_neg;
    t_wide            r_res;

    logic [XW-1:0]    mag_a, mag_b, acc_nx, q_nx, x_nx, y_nx, trial, val;
    logic [XW:0]      diff;
    logic [CNT_W:0]   sh;

    always_comb begin
        mag_a  = i_a[XW-1] ? XW'(-i_a) : XW'(i_a);
        mag_b  = i_b[XW-1] ? XW'(-i_b) : XW'(i_b);
        sh     = (CNT_W+1)'(XW) - {1'b0, i_cnt};
        trial  = {r_acc[XW-2:0], r_x[XW-1]};
        diff   = {1'b0, trial} - {1'b0, r_y};
        acc_nx = r_acc;
        q_nx   = r_q;
        x_nx   = r_x << 1;
        y_nx   = r_y;
        if (r_op == ALU_MUL) begin
            acc_nx = r_acc + (r_y[0] ? r_x : '0);
            y_nx   = r_y >> 1;
        end else if (!diff[XW]) begin
            acc_nx = diff[XW-1:0];
            q_nx   = {r_q[XW-2:0], 1'b1};
        end else begin
            acc_nx = trial;
            q_nx   = {r_q[XW-2:0], 1'b0};
        end
        val    = (r_op == ALU_MUL) ? acc_nx : q_nx;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_cnt <= i_cnt;
            r_x   <= (i_op == ALU_MUL) ? mag_a : (mag_a << sh);
            r_y   <= mag_b;
            r_acc <= '0;
            r_q   <= '0;
            r_neg <= i_a[XW-1] ^ i_b[XW-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_x   <= x_nx;
            r_y   <= y_nx;
            r_acc <= acc_nx;
            r_q   <= q_nx;
            r_res <= r_neg ? -t_wide'(val) : t_wide'(val);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[hdl/wpc_checker.sv]
// ----------------------------------------------------------------------------
// wpc_checker
// Port-level checks of the combiner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpc_checker import wpc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    logic comb_zero;

    assign comb_zero = o_data.comb_x == '0 && o_data.comb_y == '0 &&
                       o_data.comb_xx == '0 && o_data.comb_xy == '0 &&
                       o_data.comb_yy == '0;

    `WPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `WPC_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_data))
    `WPC_ASSERT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    `WPC_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> o_data.status <= ST_COMB_SING)
    `WPC_ASSERT(a_singular_zero, i_clk, i_rst_n, o_valid && o_data.status == ST_COMB_SING |-> comb_zero)

endmodule

bind weighted_point_combiner_2d_top wpc_checker u_wpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D weighted point combiner. A directed table
// covers the reset state, singular inputs, the unused kind, and the field
// extremes. Random traffic follows in four flow-control phases, each with
// its own extra variance. Every result is compared field by field against
// a table row's value or a fixed-point model of the information-form store.
// ----------------------------------------------------------------------------
module tb;
    import wpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM  = 1100;
    localparam longint LIMIT  = 8_000_000;
    localparam int  DRAIN     = 1200;

    typedef logic signed [127:0] acc_t;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } row_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;
    logic      i_cfg_we;
    logic [VALUE_WIDTH-1:0] i_cfg_wdata;

    logic [31:0]        m_extra;
    logic signed [47:0] m_wxx, m_wxy, m_wyy;
    logic signed [63:0] m_wpx, m_wpy;

    t_out_item combo_q[$];
    row_t      rows[$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    longint    cycles;

    weighted_point_combiner_2d_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic acc_t clamp(input acc_t x, input int bits);
        acc_t hi;
        hi = (acc_t'(1) <<< (bits - 1)) - acc_t'(1);
        if (x > hi) begin
            return hi;
        end
        if (x < -hi - acc_t'(1)) begin
            return -hi - acc_t'(1);
        end
        return x;
    endfunction

    function automatic acc_t merge(input logic [1:0] kind, input acc_t old_v,
                                   input acc_t val, input int bits);
        if (kind == KIND_LOAD) begin
            return val;
        end
        if (kind == KIND_ADD) begin
            return clamp(old_v + val, bits);
        end
        return clamp(old_v - val, bits);
    endfunction

    // Advances the store by a non-singular used point; returns the combination.
    function automatic t_out_item combine_point(input t_in_item it);
        t_out_item r;
        acc_t ev, px, py, a, b, d, det, nxx, nxy, nyy, qx, qy;
        acc_t wxx, wxy, wyy, wpx, wpy, cxx, cxy, cyy;
        r  = '0;
        r.status = ST_OK;
        ev = acc_t'({1'b0, m_extra});
        if (it.kind <= KIND_REMOVE) begin
            px  = acc_t'(it.pos_x);
            py  = acc_t'(it.pos_y);
            a   = clamp(acc_t'({1'b0, it.var_xx}) + ev, VALUE_WIDTH);
            b   = acc_t'(it.var_xy);
            d   = clamp(acc_t'({1'b0, it.var_yy}) + ev, VALUE_WIDTH);
            det = a * d - b * b;
            if (det == 0) begin
                r.status = ST_IN_SING;
            end else begin
                nxx = clamp((d <<< SHIFT_K) / det, WEIGHT_WIDTH);
                nxy = clamp((-b <<< SHIFT_K) / det, WEIGHT_WIDTH);
                nyy = clamp((a <<< SHIFT_K) / det, WEIGHT_WIDTH);
                qx  = clamp((nxx * px + nxy * py) >>> FRAC_BITS, WPOS_WIDTH);
                qy  = clamp((nxy * px + nyy * py) >>> FRAC_BITS, WPOS_WIDTH);
                m_wxx = WEIGHT_WIDTH'(merge(it.kind, acc_t'(m_wxx), nxx, WEIGHT_WIDTH));
                m_wxy = WEIGHT_WIDTH'(merge(it.kind, acc_t'(m_wxy), nxy, WEIGHT_WIDTH));
                m_wyy = WEIGHT_WIDTH'(merge(it.kind, acc_t'(m_wyy), nyy, WEIGHT_WIDTH));
                m_wpx = WPOS_WIDTH'(merge(it.kind, acc_t'(m_wpx), qx, WPOS_WIDTH));
                m_wpy = WPOS_WIDTH'(merge(it.kind, acc_t'(m_wpy), qy, WPOS_WIDTH));
            end
        end
        wxx = acc_t'(m_wxx);
        wxy = acc_t'(m_wxy);
        wyy = acc_t'(m_wyy);
        wpx = acc_t'(m_wpx);
        wpy = acc_t'(m_wpy);
        det = wxx * wyy - wxy * wxy;
        if (det == 0) begin
            if (r.status == ST_OK) begin
                r.status = ST_COMB_SING;
            end
        end else begin
            cxx = clamp((wyy <<< SHIFT_K) / det, COV_WIDTH);
            cxy = clamp((-wxy <<< SHIFT_K) / det, COV_WIDTH);
            cyy = clamp((wxx <<< SHIFT_K) / det, COV_WIDTH);
            r.comb_x  = VALUE_WIDTH'(clamp((cxx * wpx + cxy * wpy) >>> WEIGHT_FRAC,
                                           VALUE_WIDTH));
            r.comb_y  = VALUE_WIDTH'(clamp((cxy * wpx + cyy * wpy) >>> WEIGHT_FRAC,
                                           VALUE_WIDTH));
            r.comb_xx = VALUE_WIDTH'(clamp(cxx - ev, VALUE_WIDTH));
            r.comb_xy = VALUE_WIDTH'(clamp(cxy, VALUE_WIDTH));
            r.comb_yy = VALUE_WIDTH'(clamp(cyy - ev, VALUE_WIDTH));
        end
        return r;
    endfunction

    function automatic t_in_item make_point(input logic [1:0] kind,
            input int px, input int py, input int unsigned vxx,
            input int vxy, input int unsigned vyy);
        t_in_item it;
        it.kind   = kind;
        it.pos_x  = px;
        it.pos_y  = py;
        it.var_xx = vxx;
        it.var_xy = vxy;
        it.var_yy = vyy;
        return it;
    endfunction

    function automatic t_in_item random_point();
        t_in_item    it;
        int unsigned pick, lim;
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.kind = KIND_LOAD;
        end else if (pick < 70) begin
            it.kind = KIND_ADD;
        end else if (pick < 95) begin
            it.kind = KIND_REMOVE;
        end else begin
            it.kind = KIND_UNUSED;
        end
        if ($urandom_range(99) < 70) begin
            it.pos_x  = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            it.pos_y  = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            it.var_xx = $urandom_range(32'h0000_1000, 32'h0040_0000);
            it.var_yy = $urandom_range(32'h0000_1000, 32'h0040_0000);
            lim       = ((it.var_xx < it.var_yy) ? it.var_xx : it.var_yy) / 2;
            it.var_xy = $signed($urandom_range(0, 2 * lim)) - $signed(lim);
        end else begin
            it.pos_x  = $urandom;
            it.pos_y  = $urandom;
            it.var_xx = $urandom;
            it.var_xy = $urandom;
            it.var_yy = $urandom;
        end
        return it;
    endfunction

    task automatic write_extra(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        m_extra = value;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_point(input t_in_item it, input bit typed,
                              input t_out_item want);
        t_out_item e;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        e = combine_point(it);
        combo_q.push_back(typed ? want : e);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (combo_q.size() != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (combo_q.size() == 0) begin
                $error("Unexpected result transfer: %p", o_data);
                errors++;
            end else begin
                e = combo_q.pop_front();
                if (o_data.comb_x !== e.comb_x) begin
                    $error("comb_x expected %h actual %h", e.comb_x, o_data.comb_x);
                    errors++;
                end
                if (o_data.comb_y !== e.comb_y) begin
                    $error("comb_y expected %h actual %h", e.comb_y, o_data.comb_y);
                    errors++;
                end
                if (o_data.comb_xx !== e.comb_xx) begin
                    $error("comb_xx expected %h actual %h", e.comb_xx, o_data.comb_xx);
                    errors++;
                end
                if (o_data.comb_xy !== e.comb_xy) begin
                    $error("comb_xy expected %h actual %h", e.comb_xy, o_data.comb_xy);
                    errors++;
                end
                if (o_data.comb_yy !== e.comb_yy) begin
                    $error("comb_yy expected %h actual %h", e.comb_yy, o_data.comb_yy);
                    errors++;
                end
                if (o_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_data.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_out_item none, unit;
        row_t      r;
        int        idle_pct[4];
        int        stall_pct[4];
        logic [31:0] extra_set[4];
        int        p, k;

        idle_pct  = '{0, 88, 0, 37};
        stall_pct = '{0, 0, 88, 37};
        errors = 0;
        cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        m_extra = '0;
        m_wxx = '0; m_wxy = '0; m_wyy = '0;
        m_wpx = '0; m_wpy = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        none = '0;
        unit = '{comb_x: 32'h0001_0000, comb_y: 32'h0002_0000, comb_xx: 32'h0001_0000,
                 comb_xy: 32'h0, comb_yy: 32'h0001_0000, status: ST_OK};

        // Reset store, singular input, a unit point, then extremes.
        none.status = ST_COMB_SING;
        rows.push_back('{make_point(KIND_UNUSED, 0, 0, 0, 0, 0), 1'b1, none});
        none.status = ST_IN_SING;
        rows.push_back('{make_point(KIND_LOAD, 0, 0, 0, 0, 0), 1'b1, none});
        rows.push_back('{make_point(KIND_LOAD, 32'h0001_0000, 32'h0002_0000,
                        32'h0001_0000, 0, 32'h0001_0000), 1'b1, unit});
        rows.push_back('{make_point(KIND_ADD, 32'h0003_0000, -32'sh0001_0000,
                        32'h0002_0000, 32'h0000_8000, 32'h0001_0000), 1'b0, none});
        rows.push_back('{make_point(KIND_REMOVE, 32'h0003_0000, -32'sh0001_0000,
                        32'h0002_0000, 32'h0000_8000, 32'h0001_0000), 1'b0, none});
        rows.push_back('{make_point(KIND_ADD, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0, none});
        rows.push_back('{make_point(KIND_UNUSED, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b0, none});
        rows.push_back('{make_point(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'hFFFF_FFFF, 0, 32'hFFFF_FFFF), 1'b0, none});
        rows.push_back('{make_point(KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_0001, 0, 32'h0000_0001), 1'b0, none});
        rows.push_back('{make_point(KIND_ADD, 32'h0001_0000, 32'h0001_0000,
                        32'h0000_0001, 32'h8000_0000, 32'h0000_0001), 1'b0, none});
        rows.push_back('{make_point(KIND_LOAD, 32'h0001_0000, -32'sh0002_0000,
                        32'h0001_0000, 32'h0004_0000, 32'h0001_0000), 1'b0, none});
        rows.push_back('{make_point(KIND_REMOVE, 32'h0001_0000, -32'sh0002_0000,
                        32'h0001_0000, 32'h0004_0000, 32'h0001_0000), 1'b0, none});
        rows.push_back('{make_point(KIND_LOAD, 32'h1234_5678, 32'hFEDC_BA98,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001), 1'b0, none});
        rows.push_back('{make_point(KIND_REMOVE, 32'h0, 32'h0,
                        32'h0000_0000, 32'h0000_0000, 32'h0000_0005), 1'b0, none});
        rows.push_back('{make_point(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0001,
                        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0, none});

        write_extra(32'h0);
        foreach (rows[i]) begin
            r = rows[i];
            send_point(r.item, r.typed, r.want);
        end
        wait_drained();

        extra_set[0] = $urandom_range(0, 32'h0010_0000);
        extra_set[1] = 32'hFFFF_FFFF;
        extra_set[2] = $urandom;
        extra_set[3] = 32'h0;
        for (p = 0; p < 4; p++) begin
            write_extra(extra_set[p]);
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (k = 0; k < N_RANDOM / 4; k++) begin
                send_point(random_point(), 1'b0, none);
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && combo_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
